[hw/rtl/stack_frame_manager_assert.svh]
// assertion macros for the stack frame manager
`ifndef STACK_FRAME_MANAGER_ASSERT_SVH
`define STACK_FRAME_MANAGER_ASSERT_SVH
`ifndef SYNTHESIS
`define SFM_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sfm check failed");
`define SFM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sfm check failed");
`else
`define SFM_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define SFM_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

[hw/rtl/sfm_pkg.sv]
// shared types and constants for the stack frame manager
`timescale 1ns / 1ps
package sfm_pkg;

    localparam int FRAME_SLOTS = 5;
    localparam int SLOT_W      = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;

    localparam logic [8:0] STACK_START = 9'd394;
    localparam logic [8:0] FRAME_MIN   = 9'd10;
    localparam int         FRAME_MAX   = 80;
    localparam int         STACK_ROOM  = 180;
    localparam int         STACK_FLOOR = 394 - STACK_ROOM;

    localparam int PADDR_W = 3;

    typedef enum logic [1:0] {
        REQ_CREATE_FRAME = 2'd0,
        REQ_DELETE_FRAME = 2'd1,
        REQ_CREATE_VAR   = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_NAME  = 3'd1,
        ST_NO_ROOM   = 3'd2,
        ST_EXISTS    = 3'd3,
        ST_NO_SLOT   = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_TOO_BIG   = 3'd6
    } t_status;

    typedef enum logic {
        REG_HEAP_TOP = 1'b0
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [63:0]        frame_name;
        logic [3:0]         name_length;
        logic signed [31:0] func_address;
        logic [3:0]         var_size;
        logic [63:0]        var_value;
    } t_req_item;

    typedef struct packed {
        t_status     status;
        logic [3:0]  write_bytes;
        logic [8:0]  write_address;
        logic [63:0] write_data;
        logic [8:0]  stack_pointer_now;
    } t_result_item;

    typedef struct packed {
        logic        push;
        logic        pop;
        logic [63:0] name;
        logic [8:0]  base;
        logic [31:0] func_address;
    } t_slot_cmd;

    typedef struct packed {
        logic              free_found;
        logic              name_exists;
        logic              top_found;
        logic [SLOT_W-1:0] top_idx;
        logic [8:0]        top_base;
    } t_slot_view;

endpackage

[hw/rtl/stack_frame_manager.sv]
// top level of the stack frame manager: request and result stages, stack pointer, apb register
//
// usage
// - request items enter on i_in_valid / o_in_ready with payload i_in_item; result items
//   leave on o_out_valid / i_out_ready with payload o_out_item, one result per request
// - each request is held in an input register, checked combinationally against the stack
//   pointer and the slot table, and its result lands in the output register
// - a request passes through the input register, then the output register drives o_out_valid
// - throughput: one item per cycle while the receiver does not stall, since the stack pointer
//   and slot table update at the same edge the result is stored
// - when the receiver stalls, the output register holds its item and the input register
//   keeps one more; o_in_ready drops only when both are full
// - the user writes heap_top at apb byte address 0 only while idle; the block does not check
// - reset: stack pointer to 394, all slots free, heap_top to 0, both stages empty
`timescale 1ns / 1ps
`include "stack_frame_manager_assert.svh"
module stack_frame_manager import sfm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_req_item          i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_result_item       o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic         r_in_valid;
    t_req_item    r_in;
    logic         r_out_valid;
    t_result_item r_out;
    logic [8:0]   r_sp;
    logic [8:0]   r_heap_top;

    logic         out_adv;
    logic         fire;
    logic [8:0]   n_sp;
    t_result_item res;
    t_slot_cmd    cmd;
    t_slot_view   view;
    logic [63:0]  masked_name;
    logic [63:0]  masked_value;
    logic signed [11:0] sp_s;
    logic signed [11:0] heap_s;
    logic signed [11:0] size_s;
    logic signed [11:0] diff_frame;
    logic signed [11:0] diff_var;
    logic signed [11:0] frame_use;
    logic         frame_room_fail;
    logic         var_room_fail;
    logic         size_ok;

    assign out_adv    = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && out_adv;
    assign o_in_ready = !r_in_valid || out_adv;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEAP_TOP) ? {23'd0, r_heap_top} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_top <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_HEAP_TOP) begin
            r_heap_top <= pwdata[8:0];
        end
    end

    // name and value masks by byte count
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            masked_name[8*k +: 8]  = (4'(k) < r_in.name_length) ?
                                     r_in.frame_name[8*k +: 8] : 8'd0;
            masked_value[8*k +: 8] = (4'(k) < r_in.var_size) ?
                                     r_in.var_value[8*k +: 8] : 8'd0;
        end
    end

    always_comb begin
        sp_s            = $signed({3'd0, r_sp});
        heap_s          = $signed({3'd0, r_heap_top});
        size_s          = $signed({8'd0, r_in.var_size});
        diff_frame      = sp_s - $signed({3'd0, FRAME_MIN});
        diff_var        = sp_s - size_s;
        frame_use       = $signed({3'd0, view.top_base}) - sp_s - size_s;
        frame_room_fail = (diff_frame < 12'sd214) || (diff_frame <= heap_s);
        var_room_fail   = (diff_var < 12'(STACK_FLOOR)) || (diff_var <= heap_s);
        size_ok         = (r_in.var_size == 4'd1) || (r_in.var_size == 4'd4) ||
                          (r_in.var_size == 4'd8);
    end

    always_comb begin
        n_sp              = r_sp;
        res.status        = ST_OK;
        res.write_bytes   = '0;
        res.write_address = '0;
        res.write_data    = '0;
        cmd.push          = 1'b0;
        cmd.pop           = 1'b0;
        cmd.name          = masked_name;
        cmd.base          = r_sp;
        cmd.func_address  = r_in.func_address;
        case (r_in.req_type)
            REQ_CREATE_FRAME: begin
                if (r_in.name_length == 4'd0 || r_in.name_length > 4'd8) begin
                    res.status = ST_BAD_NAME;
                end else if (frame_room_fail) begin
                    res.status = ST_NO_ROOM;
                end else if (view.name_exists) begin
                    res.status = ST_EXISTS;
                end else if (!view.free_found) begin
                    res.status = ST_NO_SLOT;
                end else begin
                    cmd.push = fire;
                    n_sp     = r_sp - FRAME_MIN;
                end
            end
            REQ_DELETE_FRAME: begin
                if (!view.top_found) begin
                    res.status = ST_EMPTY;
                end else begin
                    cmd.pop = fire;
                    n_sp    = view.top_base;
                end
            end
            REQ_CREATE_VAR: begin
                if (!size_ok) begin
                    res.status = ST_BAD_NAME;
                end else if (var_room_fail) begin
                    res.status = ST_NO_ROOM;
                end else if (!view.top_found) begin
                    res.status = ST_EMPTY;
                end else if (frame_use > 12'(FRAME_MAX)) begin
                    res.status = ST_TOO_BIG;
                end else begin
                    n_sp              = r_sp - {5'd0, r_in.var_size};
                    res.write_bytes   = r_in.var_size;
                    res.write_address = r_sp - {5'd0, r_in.var_size};
                    res.write_data    = masked_value;
                end
            end
            default: begin
                n_sp = r_sp;
            end
        endcase
        res.stack_pointer_now = n_sp;
    end

    sfm_slot_table u_slots (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_query_name (masked_name),
        .i_cmd        (cmd),
        .o_view       (view)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sp        <= STACK_START;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_sp <= n_sp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `SFM_ASSERT_IMPL(a_sp_range, i_clk, i_rst_n, 1'b1,
        r_sp <= STACK_START && r_sp >= 9'(STACK_FLOOR))
    `SFM_ASSERT_IMPL(a_fail_no_write, i_clk, i_rst_n,
        r_out_valid && r_out.status != ST_OK, r_out.write_bytes == 4'd0)
    `SFM_ASSERT_NEXT(a_result_sp, i_clk, i_rst_n, fire,
        r_out.stack_pointer_now == r_sp)
    `SFM_ASSERT_IMPL(a_write_below_sp, i_clk, i_rst_n,
        fire && res.write_bytes != 4'd0, res.write_address == n_sp)

endmodule

[hw/rtl/sfm_slot_table.sv]
// frame slot table: slot storage, name lookup, free and top slot search
`timescale 1ns / 1ps
`include "stack_frame_manager_assert.svh"
module sfm_slot_table import sfm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [63:0] i_query_name,
    input  t_slot_cmd   i_cmd,
    output t_slot_view  o_view
);

    logic [FRAME_SLOTS-1:0] r_used;
    logic [63:0]            r_name [FRAME_SLOTS];
    logic [8:0]             r_base [FRAME_SLOTS];
    logic [31:0]            r_func [FRAME_SLOTS];

    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              name_exists;
    logic [SLOT_W-1:0] top_idx;

    // scan stops at the first free slot
    always_comb begin
        free_found  = 1'b0;
        free_idx    = '0;
        name_exists = 1'b0;
        for (int i = 0; i < FRAME_SLOTS; i++) begin
            if (!free_found) begin
                if (!r_used[i]) begin
                    free_found = 1'b1;
                    free_idx   = SLOT_W'(i);
                end else if (r_name[i] == i_query_name) begin
                    name_exists = 1'b1;
                end
            end
        end
        top_idx = free_found ? (free_idx - 1'b1) : SLOT_W'(FRAME_SLOTS - 1);
    end

    always_comb begin
        o_view.free_found  = free_found;
        o_view.name_exists = name_exists;
        o_view.top_found   = r_used[0];
        o_view.top_idx     = top_idx;
        o_view.top_base    = r_base[top_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.push) begin
            r_used[free_idx] <= 1'b1;
        end else if (i_cmd.pop) begin
            r_used[top_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_name[free_idx] <= i_cmd.name;
            r_base[free_idx] <= i_cmd.base;
            r_func[free_idx] <= i_cmd.func_address;
        end
    end

    `SFM_ASSERT_IMPL(a_push_pop_excl, i_clk, i_rst_n, i_cmd.push, !i_cmd.pop)
    `SFM_ASSERT_IMPL(a_push_has_free, i_clk, i_rst_n, i_cmd.push, free_found)
    `SFM_ASSERT_IMPL(a_pop_has_top, i_clk, i_rst_n, i_cmd.pop, r_used[0])

endmodule
